[design/lsd_pkg.sv]
`default_nettype none

package lsd_pkg;

    // Default geometry of the history window and the match length field
    localparam int WINDOW_BITS_DEF = 12;
    localparam int LENGTH_BITS_DEF = 4;

    // Input operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MATCH_BIAS   = 2'd0;
    localparam logic [1:0] CFG_START_GAP    = 2'd1;
    localparam logic [1:0] CFG_FILL_BYTE    = 2'd2;
    localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd3;

    // Configuration reset values
    localparam logic [1:0]  RST_MATCH_BIAS   = 2'd2;
    localparam logic [11:0] RST_START_GAP    = 12'd2;
    localparam logic [7:0]  RST_FILL_BYTE    = 8'd0;
    localparam logic [31:0] RST_OUTPUT_LIMIT = 32'hFFFF_FFFF;

    // Commands to the history window
    typedef struct packed {
        logic restart;  // new stream: rewind write pointer, forget contents
        logic push;     // append one decoded byte
    } t_win_cmd;

endpackage

`default_nettype wire

[design/lsd_window.sv]
`default_nettype none

// History window: one synchronous RAM, written at a running pointer and read
// at any address through a registered read port. Entries not yet written in the
// current stream read as the stream's fill byte (tracked by a fill count, as
// writes always advance from the stream's start position). A read of the
// entry written in the same cycle is forwarded.
module lsd_window #(
    parameter int WB = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lsd_pkg::t_win_cmd    i_cmd,
    input  wire [WB-1:0]         i_start_pos,
    input  wire [7:0]            i_fill,
    input  wire [7:0]            i_wr_data,
    input  wire [WB-1:0]         i_rd_addr,
    output logic [7:0]           o_rd_data
);
    import lsd_pkg::*;

    localparam int DEPTH = 1 << WB;
    localparam logic [WB:0] FULL = (WB + 1)'(DEPTH);

    logic [7:0]  r_mem [DEPTH];
    logic [7:0]  r_q;
    logic [WB-1:0] r_wpos;
    logic [WB-1:0] r_start;
    logic [WB:0]   r_fill_cnt;
    logic [WB:0]   n_fill_cnt;
    logic [7:0]    r_fill_byte;
    logic          r_fwd;
    logic [7:0]    r_fwd_data;
    logic          r_ok;
    logic [WB-1:0] rd_offset;

    // Memory array: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wpos] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    // Written-entry count, saturating at the window size
    always_comb begin
        if (i_cmd.restart) begin
            n_fill_cnt = '0;
        end else if (i_cmd.push && r_fill_cnt != FULL) begin
            n_fill_cnt = r_fill_cnt + 1'b1;
        end else begin
            n_fill_cnt = r_fill_cnt;
        end
    end

    assign rd_offset = i_rd_addr - r_start;

    // Fill count and forwarding flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_fill_cnt <= n_fill_cnt;
            r_fwd      <= i_cmd.push && !i_cmd.restart && (r_wpos == i_rd_addr);
        end
    end

    // Payload side: positions, fill byte, read qualifiers
    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            r_wpos      <= i_start_pos;
            r_start     <= i_start_pos;
            r_fill_byte <= i_fill;
        end else if (i_cmd.push) begin
            r_wpos <= r_wpos + 1'b1;
        end
        r_fwd_data <= i_wr_data;
        r_ok       <= ({1'b0, rd_offset} < n_fill_cnt);
    end

    // Effective read byte
    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_ok) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data = r_fill_byte;
        end
    end

endmodule

`default_nettype wire

[design/lzss_stream_decoder_unit.sv]
`default_nettype none

// LZSS stream decoder.
// Input channel (i_valid/o_ready) carries one op per transfer: a compressed
// byte, begin new stream, or end of stream. Output channel (o_valid/i_ready)
// carries one result per transfer: a decoded byte, an output limit error or
// an end of stream summary; o_last marks the final result of an input item.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data at any
// edge, no handshake.
// Sequencing: an item that gives no result is taken in the idle state. A
// literal passes through the literal state, which loads its result into the
// output register. A match of n bytes gives n results: the window RAM read
// is registered, and the copy then moves one byte per cycle while the output
// register can take it, each byte written back to the RAM as it is emitted.
// With the default length field a match gives up to 19 bytes.
// The input is taken only between items; a finished result waits in the
// output register while the next input is taken.
// Stalls: while i_ready is low and the output register is full, the copy or
// literal holds in place; nothing is lost.
// Reset: configuration returns to its defaults and a fresh stream starts;
// the window needs no clearing pass, unwritten entries read as the fill
// byte.
module lzss_stream_decoder_unit #(
    parameter int WINDOW_BITS = lsd_pkg::WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = lsd_pkg::LENGTH_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_op,
    input  wire [7:0]   i_in_byte,
    // Output channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_stream_bytes,
    output logic        o_last,
    // Configuration
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);
    import lsd_pkg::*;

    localparam int WB = WINDOW_BITS;
    localparam int LB = LENGTH_BITS;
    localparam int CW = LB + 2;
    localparam logic [WB-1:0] TOP_POS = WB'((1 << WB) - (1 << LB));

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LIT  = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    // Token phases
    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // Configuration
    logic [1:0]  r_bias;
    logic [11:0] r_gap;
    logic [7:0]  r_fill;
    logic [31:0] r_limit;

    // Decoder state
    logic [1:0]    r_state, n_state;
    logic [8:0]    r_flags, n_flags;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_held, n_held;
    logic [31:0]   r_count, n_count;
    logic          r_err, n_err;
    logic [7:0]    r_lit, n_lit;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [WB-1:0] r_rd_addr, n_rd_addr;

    // Output register
    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_kind, n_o_kind;
    logic [7:0]    r_o_data, n_o_data;
    logic [31:0]   r_o_total, n_o_total;
    logic          r_o_last, n_o_last;

    // Window interface
    t_win_cmd      win_cmd;
    logic [WB-1:0] start_pos;
    logic [11:0]   gap_sel;
    logic [7:0]    fill_sel;
    logic [7:0]    wr_data;
    logic [WB-1:0] rd_addr;
    logic [7:0]    win_byte;

    logic          in_xfer;
    logic          slot_free;
    logic          lim_hit;
    logic          restart;
    logic [WB-1:0] match_pos;
    logic [8:0]    flags_sh;

    assign o_ready        = (r_state == S_IDLE);
    assign in_xfer        = i_valid && o_ready;
    assign slot_free      = !r_o_valid || i_ready;
    assign lim_hit        = (r_count >= r_limit);
    assign flags_sh       = {1'b0, r_flags[8:1]};
    assign match_pos      = WB'({i_in_byte[7:LB], r_held});

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_data_byte    = r_o_data;
    assign o_stream_bytes = r_o_total;
    assign o_last         = r_o_last;

    // Stream start position and fill byte, taken from reset values while in reset
    assign gap_sel   = i_rst_n ? r_gap : RST_START_GAP;
    assign fill_sel  = i_rst_n ? r_fill : RST_FILL_BYTE;
    assign start_pos = TOP_POS - WB'(gap_sel);

    // Sequencer and token decode
    always_comb begin
        n_state   = r_state;
        n_flags   = r_flags;
        n_phase   = r_phase;
        n_held    = r_held;
        n_count   = r_count;
        n_err     = r_err;
        n_lit     = r_lit;
        n_cnt     = r_cnt;
        n_rd_addr = r_rd_addr;
        n_o_valid = r_o_valid && !i_ready;
        n_o_kind  = r_o_kind;
        n_o_data  = r_o_data;
        n_o_total = r_o_total;
        n_o_last  = r_o_last;
        restart   = 1'b0;
        win_cmd   = '0;
        wr_data   = r_lit;
        rd_addr   = r_rd_addr;

        case (r_state)
            S_IDLE: begin
                rd_addr = match_pos;
                if (in_xfer) begin
                    if (i_op == OP_START) begin
                        restart = 1'b1;
                    end else if (!r_err && i_op == OP_END) begin
                        n_state = S_END;
                    end else if (!r_err && i_op == OP_BYTE) begin
                        case (r_phase)
                            PH_FLAG: begin
                                n_flags = {1'b1, i_in_byte};
                                n_phase = PH_TOKEN;
                            end
                            PH_TOKEN: begin
                                if (r_flags[0]) begin
                                    n_lit   = i_in_byte;
                                    n_state = S_LIT;
                                end else begin
                                    n_held  = i_in_byte;
                                    n_phase = PH_SECOND;
                                end
                            end
                            default: begin
                                n_rd_addr = match_pos;
                                n_cnt     = CW'(i_in_byte[LB-1:0]) + CW'(r_bias) + CW'(1);
                                n_held    = '0;
                                n_state   = S_COPY;
                            end
                        endcase
                    end
                end
            end
            S_LIT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    if (lim_hit) begin
                        n_o_kind  = KIND_ERROR;
                        n_o_data  = '0;
                        n_o_total = r_count;
                        n_err     = 1'b1;
                    end else begin
                        n_o_kind     = KIND_BYTE;
                        n_o_data     = r_lit;
                        n_o_total    = r_count + 1'b1;
                        n_count      = r_count + 1'b1;
                        win_cmd.push = 1'b1;
                    end
                    n_flags = flags_sh;
                    n_phase = (flags_sh <= 9'd1) ? PH_FLAG : PH_TOKEN;
                    n_state = S_IDLE;
                end
            end
            S_COPY: begin
                wr_data = win_byte;
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    if (lim_hit) begin
                        n_o_kind  = KIND_ERROR;
                        n_o_data  = '0;
                        n_o_total = r_count;
                        n_o_last  = 1'b1;
                        n_err     = 1'b1;
                        n_flags   = flags_sh;
                        n_phase   = (flags_sh <= 9'd1) ? PH_FLAG : PH_TOKEN;
                        n_state   = S_IDLE;
                    end else begin
                        n_o_kind     = KIND_BYTE;
                        n_o_data     = win_byte;
                        n_o_total    = r_count + 1'b1;
                        n_o_last     = (r_cnt == CW'(1));
                        n_count      = r_count + 1'b1;
                        win_cmd.push = 1'b1;
                        n_cnt        = r_cnt - 1'b1;
                        // Fetch the next source byte while this one is written
                        rd_addr      = r_rd_addr + 1'b1;
                        n_rd_addr    = r_rd_addr + 1'b1;
                        if (r_cnt == CW'(1)) begin
                            n_flags = flags_sh;
                            n_phase = (flags_sh <= 9'd1) ? PH_FLAG : PH_TOKEN;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                // End of stream summary, then a fresh stream
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_SUMMARY;
                    n_o_data  = '0;
                    n_o_total = r_count;
                    n_o_last  = 1'b1;
                    restart   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
        endcase

        if (restart) begin
            n_flags = '0;
            n_phase = PH_FLAG;
            n_held  = '0;
            n_count = '0;
            n_err   = 1'b0;
        end
        win_cmd.restart = restart || !i_rst_n;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= RST_MATCH_BIAS;
            r_gap   <= RST_START_GAP;
            r_fill  <= RST_FILL_BYTE;
            r_limit <= RST_OUTPUT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATCH_BIAS:   r_bias  <= i_cfg_data[1:0];
                CFG_START_GAP:    r_gap   <= i_cfg_data[11:0];
                CFG_FILL_BYTE:    r_fill  <= i_cfg_data[7:0];
                CFG_OUTPUT_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_flags   <= '0;
            r_phase   <= PH_FLAG;
            r_held    <= '0;
            r_count   <= '0;
            r_err     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flags   <= n_flags;
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_count   <= n_count;
            r_err     <= n_err;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lit     <= n_lit;
        r_cnt     <= n_cnt;
        r_rd_addr <= n_rd_addr;
        r_o_kind  <= n_o_kind;
        r_o_data  <= n_o_data;
        r_o_total <= n_o_total;
        r_o_last  <= n_o_last;
    end

    lsd_window #(
        .WB (WB)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (win_cmd),
        .i_start_pos (start_pos),
        .i_fill      (fill_sel),
        .i_wr_data   (wr_data),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (win_byte)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
module tb_top;
    import lsd_pkg::*;

    // Window geometry at the default parameters
    localparam int          WIN_SIZE     = 1 << WINDOW_BITS_DEF;
    localparam logic [11:0] WIN_START    = 12'(WIN_SIZE - (1 << LENGTH_BITS_DEF));
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          N_PHASES     = 8;
    localparam int          RAND_ITEMS   = 36;
    localparam int          DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH} t_tok_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] b;
    } t_comp_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] count;
        logic        last;
    } t_dec_res;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_op       = OP_BYTE;
    logic [7:0]  i_in_byte  = 8'h00;
    logic        i_ready    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_MATCH_BIAS;
    logic [31:0] i_cfg_data = 32'h0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_stream_bytes;
    logic        o_last;

    // Stimulus queue and expected decoder output
    t_comp_item comp_q[$];
    t_dec_res   decode_q[$];
    int         err_count     = 0;
    int         phase_items   = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic [11:0] gen_pos;

    // Decoder shadow: configuration and stream state
    logic [1:0]  cfg_bias;
    logic [11:0] cfg_gap;
    logic [7:0]  cfg_fill;
    logic [31:0] cfg_limit;
    logic [7:0]  hist_win [0:WIN_SIZE-1];
    logic [11:0] m_wpos;
    logic [8:0]  m_flags;
    t_tok_phase  m_phase;
    logic [7:0]  m_off_lo;
    logic [31:0] m_count;
    logic        m_err;
    t_dec_res    held_res;
    logic        have_res;

    lzss_stream_decoder_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_stream_bytes (o_stream_bytes),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------- decoder shadow ----------------

    task automatic restart_stream();
        for (int i = 0; i < WIN_SIZE; i++)
            hist_win[i] = cfg_fill;
        m_wpos   = WIN_START - cfg_gap;
        m_flags  = '0;
        m_phase  = PH_FLAG;
        m_off_lo = '0;
        m_count  = '0;
        m_err    = 1'b0;
    endtask

    task automatic model_reset();
        cfg_bias  = RST_MATCH_BIAS;
        cfg_gap   = RST_START_GAP;
        cfg_fill  = RST_FILL_BYTE;
        cfg_limit = RST_OUTPUT_LIMIT;
        restart_stream();
    endtask

    // Results of one step are held back by one so the final one gets last set
    function automatic void add_result(input logic [1:0] kind, input logic [7:0] data);
        if (have_res)
            decode_q.push_back(held_res);
        held_res = '{kind: kind, data: data, count: m_count, last: 1'b0};
        have_res = 1'b1;
    endfunction

    function automatic bit emit_byte(input logic [7:0] c);
        if (m_count >= cfg_limit) begin
            add_result(KIND_ERROR, 8'h00);
            m_err = 1'b1;
            return 1'b0;
        end
        m_count++;
        add_result(KIND_BYTE, c);
        hist_win[m_wpos] = c;
        m_wpos++;
        return 1'b1;
    endfunction

    task automatic next_token();
        m_flags = m_flags >> 1;
        m_phase = (m_flags <= 9'd1) ? PH_FLAG : PH_TOKEN;
    endtask

    task automatic lzss_decode_item(input logic [1:0] op, input logic [7:0] b);
        logic [11:0] src;
        int unsigned len;
        have_res = 1'b0;
        if (op == OP_START) begin
            restart_stream();
            return;
        end
        if (m_err || op == OP_UNUSED)
            return;
        if (op == OP_END) begin
            add_result(KIND_SUMMARY, 8'h00);
            restart_stream();
        end else if (m_phase == PH_FLAG) begin
            m_flags = {1'b1, b};
            m_phase = PH_TOKEN;
        end else if (m_phase == PH_TOKEN) begin
            if (m_flags[0]) begin
                void'(emit_byte(b));
                next_token();
            end else begin
                m_off_lo = b;
                m_phase  = PH_MATCH;
            end
        end else begin
            src      = {b[7:4], m_off_lo};
            len      = 32'(b[3:0]) + 32'(cfg_bias) + 1;
            m_off_lo = '0;
            // copy may read bytes written earlier in the same copy
            for (int k = 0; k < len; k++)
                if (!emit_byte(hist_win[src + 12'(k)]))
                    break;
            next_token();
        end
        if (have_res) begin
            held_res.last = 1'b1;
            decode_q.push_back(held_res);
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic queue_op(input logic [1:0] op, input logic [7:0] b);
        comp_q.push_back('{op: op, b: b});
        phase_items++;
    endtask

    // One compressed stream: flag groups with random tokens, matches mostly
    // pointing just behind the write position, sometimes cut short
    task automatic gen_stream();
        int n_groups;
        logic [7:0]  flags;
        logic [11:0] off;
        logic [3:0]  len;
        if ($urandom_range(9) != 0)
            queue_op(OP_START, 8'($urandom));
        gen_pos  = WIN_START - cfg_gap;
        n_groups = $urandom_range(1, 3);
        for (int g = 0; g < n_groups; g++) begin
            flags = 8'($urandom);
            queue_op(OP_BYTE, flags);
            for (int t = 0; t < 8; t++) begin
                if ($urandom_range(24) == 0)
                    queue_op(OP_UNUSED, 8'($urandom));
                if (flags[t]) begin
                    queue_op(OP_BYTE, 8'($urandom));
                    gen_pos++;
                end else begin
                    if ($urandom_range(3) != 0)
                        off = gen_pos - 12'($urandom_range(1, 24));
                    else
                        off = 12'($urandom);
                    len = 4'($urandom);
                    queue_op(OP_BYTE, off[7:0]);
                    queue_op(OP_BYTE, {off[11:8], len});
                    gen_pos += 12'(len) + 12'(cfg_bias) + 12'd1;
                end
            end
        end
        // truncated token: lone flag byte or half a match
        case ($urandom_range(7))
            0: queue_op(OP_BYTE, 8'($urandom));
            1: begin
                queue_op(OP_BYTE, 8'h00);
                queue_op(OP_BYTE, 8'($urandom));
            end
            default: ;
        endcase
        if ($urandom_range(9) != 0)
            queue_op(OP_END, 8'($urandom));
    endtask

    task automatic fill_random(input int budget);
        phase_items = 0;
        while (phase_items < budget) begin
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 3))
                    queue_op(2'($urandom), 8'($urandom));
            end else begin
                gen_stream();
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MATCH_BIAS:   cfg_bias  = data[1:0];
            CFG_START_GAP:    cfg_gap   = data[11:0];
            CFG_FILL_BYTE:    cfg_fill  = data[7:0];
            CFG_OUTPUT_LIMIT: cfg_limit = data;
            default: ;
        endcase
    endtask

    task automatic set_phase(input int p);
        case (p)
            1: begin
                write_reg(CFG_MATCH_BIAS, 32'd0);
                write_reg(CFG_START_GAP, 32'd0);
                write_reg(CFG_FILL_BYTE, 32'hFF);
                write_reg(CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
            end
            2: begin
                write_reg(CFG_MATCH_BIAS, 32'd3);
                write_reg(CFG_START_GAP, 32'd4080);
                write_reg(CFG_FILL_BYTE, 32'hA5);
                write_reg(CFG_OUTPUT_LIMIT, 32'd0);
            end
            3: begin
                write_reg(CFG_MATCH_BIAS, 32'd1);
                write_reg(CFG_START_GAP, 32'd17);
                write_reg(CFG_FILL_BYTE, 32'h00);
                write_reg(CFG_OUTPUT_LIMIT, 32'd40);
            end
            4: begin
                write_reg(CFG_MATCH_BIAS, 32'd3);
                write_reg(CFG_START_GAP, 32'hFFF);
                write_reg(CFG_FILL_BYTE, 32'h3C);
                write_reg(CFG_OUTPUT_LIMIT, 32'h8000_0000);
            end
            5: begin
                write_reg(CFG_MATCH_BIAS, 32'($urandom_range(3)));
                write_reg(CFG_START_GAP, 32'($urandom_range(4095)));
                write_reg(CFG_FILL_BYTE, 32'($urandom_range(255)));
                write_reg(CFG_OUTPUT_LIMIT, 32'($urandom_range(300)));
            end
            6: begin
                write_reg(CFG_MATCH_BIAS, 32'($urandom_range(3)));
                write_reg(CFG_START_GAP, 32'($urandom_range(4095)));
                write_reg(CFG_FILL_BYTE, 32'($urandom_range(255)));
                write_reg(CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
            end
            default: begin
                write_reg(CFG_MATCH_BIAS, 32'd0);
                write_reg(CFG_START_GAP, 32'd4080);
                write_reg(CFG_FILL_BYTE, 32'h5C);
                write_reg(CFG_OUTPUT_LIMIT, 32'd1);
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every item is sent and every result is back, then lets
    // a dropped token or a long copy finish; sampled at the falling edge so
    // the driver's updates of the rising edge have settled
    task automatic wait_idle();
        while (comp_q.size() != 0 || i_valid || decode_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_comp_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                lzss_decode_item(i_op, i_in_byte);
            // slot free once the current item transfers
            if (!i_valid || o_ready) begin
                if (comp_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = comp_q.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= nxt.op;
                    i_in_byte <= nxt.b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_dec_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (decode_q.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing expected", o_kind));
                end else begin
                    want = decode_q.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                    if (o_data_byte !== want.data)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  o_data_byte, want.data));
                    if (o_stream_bytes !== want.count)
                        report_mismatch($sformatf("stream_bytes %0d, want %0d",
                                                  o_stream_bytes, want.count));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- run control ----------------
    initial begin
        model_reset();

        // Directed part under reset configuration
        queue_op(OP_START, 8'h00);
        queue_op(OP_BYTE, 8'hFD);       // literal, match, then literals
        queue_op(OP_BYTE, 8'hFF);
        queue_op(OP_BYTE, 8'hFE);       // longest match, wraps the window
        queue_op(OP_BYTE, 8'hFF);
        queue_op(OP_BYTE, 8'h00);
        queue_op(OP_UNUSED, 8'hFF);     // unused op, ignored
        queue_op(OP_BYTE, 8'h80);
        queue_op(OP_END, 8'h00);
        queue_op(OP_BYTE, 8'h01);       // literal then matches
        queue_op(OP_BYTE, 8'h5A);
        queue_op(OP_BYTE, 8'hEE);       // match on its own output
        queue_op(OP_BYTE, 8'hF0);
        queue_op(OP_BYTE, 8'h00);       // half a match, dropped at end
        queue_op(OP_END, 8'hFF);
        queue_op(OP_END, 8'h00);        // empty stream
        queue_op(OP_BYTE, 8'h00);       // flag byte without token
        queue_op(OP_END, 8'h00);
        queue_op(OP_START, 8'hFF);
        queue_op(OP_BYTE, 8'h00);
        queue_op(OP_BYTE, 8'h00);       // match of fill bytes
        queue_op(OP_BYTE, 8'h00);
        queue_op(OP_END, 8'h00);
        fill_random(RAND_ITEMS);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 1; p < N_PHASES; p++) begin
            wait_idle();
            set_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            fill_random(RAND_ITEMS);
        end

        wait_idle();
        if (decode_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decode_q.size()));
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
